// ===== sv/gtaap_pkg.sv =====
// gtaap_pkg: widths, reset values, codes and shared types of the atlas packer
// used by every module of the block; depends on nothing

package gtaap_pkg;

  localparam int CELL_W    = 15;
  localparam int EXT_W     = 15;
  localparam int GROW_W    = 16;
  localparam int PROD1_W   = 30;
  localparam int TEX_W     = 45;
  localparam int BUDGET_W  = 43;
  localparam int SLOT_W    = 33;
  localparam int NSLOT_W   = 34;
  localparam int BRICK_W   = 21;
  localparam int VOL_W     = 7;
  localparam int OFF_W     = 14;
  localparam int IDX_W     = 6;
  localparam int BASE_W    = 32;
  localparam int SKIP_W    = 2;
  localparam int AXIS_W    = 2;
  localparam int CFG_W     = 43;
  localparam int CFG_IDX_W = 2;
  localparam int NPACK     = 3;
  localparam int STEP_W    = 3;

  // most boxes ever packed, whatever volume_limit says
  localparam logic [VOL_W-1:0] MAX_BOXES = 7'd16;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NPACK - 1);

  localparam logic [NPACK-1:0] ALL_AXES = 3'b111;

  // register reset values
  localparam logic [CELL_W-1:0]   AXIS_LIMIT_RST    = 15'd2048;
  localparam logic [BUDGET_W-1:0] TEXEL_BUDGET_RST  = 43'd16777216;
  localparam logic [SLOT_W-1:0]   SLOT_CAPACITY_RST = 33'd32768;
  localparam logic [VOL_W-1:0]    VOLUME_LIMIT_RST  = 7'd16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_BUDGET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CAPACITY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LIMIT  = 2'd3;

  // skip reasons
  localparam logic [SKIP_W-1:0] SKIP_NONE  = 2'd0;
  localparam logic [SKIP_W-1:0] SKIP_FULL  = 2'd1;
  localparam logic [SKIP_W-1:0] SKIP_NOFIT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] pack;
    logic       phase;
    logic       decide;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic                accepted;
    logic [SKIP_W-1:0]   skip_reason;
    logic [IDX_W-1:0]    packed_index;
    logic [BASE_W-1:0]   slot_base;
    logic [OFF_W-1:0]    offset_in_x_stack;
    logic [OFF_W-1:0]    offset_in_y_stack;
    logic [OFF_W-1:0]    offset_in_z_stack;
    logic [AXIS_W-1:0]   best_axis;
    logic [BUDGET_W-1:0] best_texels;
    logic [SLOT_W-1:0]   total_slots;
  } res_t;

endpackage

// ===== sv/gtaap_in_if.sv =====
// gtaap_in_if: box channel into the atlas packer, valid/ready plus box fields
// depends on nothing

interface gtaap_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [14:0] cells_x;
  logic [14:0] cells_y;
  logic [14:0] cells_z;
  logic [20:0] brick_count;

  modport source (output valid, output restart, output cells_x, output cells_y,
                  output cells_z, output brick_count, input ready);
  modport sink (input valid, input restart, input cells_x, input cells_y,
                input cells_z, input brick_count, output ready);
endinterface

// ===== sv/gtaap_out_if.sv =====
// gtaap_out_if: result channel of the atlas packer, valid/ready plus result fields
// depends on nothing

interface gtaap_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  skip_reason;
  logic [5:0]  packed_index;
  logic [31:0] slot_base;
  logic [13:0] offset_in_x_stack;
  logic [13:0] offset_in_y_stack;
  logic [13:0] offset_in_z_stack;
  logic [1:0]  best_axis;
  logic [42:0] best_texels;
  logic [32:0] total_slots;

  modport source (output valid, output accepted, output skip_reason, output packed_index,
                  output slot_base, output offset_in_x_stack, output offset_in_y_stack,
                  output offset_in_z_stack, output best_axis, output best_texels,
                  output total_slots, input ready);
  modport sink (input valid, input accepted, input skip_reason, input packed_index,
                input slot_base, input offset_in_x_stack, input offset_in_y_stack,
                input offset_in_z_stack, input best_axis, input best_texels,
                input total_slots, output ready);
endinterface

// ===== sv/gtaap_ctrl.sv =====
// gtaap_ctrl: sequencer of the atlas packer, steps the shared multiplier
// and the decide and publish cycles; depends on gtaap_pkg

module gtaap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output gtaap_pkg::cmd_t   cmd
);

  gtaap_pkg::state_t                 state_r, state_nxt;
  logic [gtaap_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gtaap_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      gtaap_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = gtaap_pkg::ST_MUL;
        end
      end
      gtaap_pkg::ST_MUL: begin
        // two steps per packing: first pair product, then times the third extent
        cmd.mul_en = 1'b1;
        cmd.pack   = step_r[2:1];
        cmd.phase  = step_r[0];
        if (step_r == gtaap_pkg::LAST_STEP) begin
          state_nxt = gtaap_pkg::ST_DECIDE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      gtaap_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = gtaap_pkg::ST_PUBLISH;
      end
      gtaap_pkg::ST_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = gtaap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gtaap_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.publish | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

  a_load_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gtaap_pkg::ST_IDLE && in_valid) |=>
      (state_r == gtaap_pkg::ST_MUL && step_r == 3'd0))
    else $error("accepted box did not start the multiply sequence");

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("published result not marked valid");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gtaap_pkg::ST_MUL |-> step_r <= gtaap_pkg::LAST_STEP)
    else $error("multiply step out of range");

endmodule

// ===== sv/gtaap_dp.sv =====
// gtaap_dp: datapath of the atlas packer, config registers, packing state,
// shared multiplier, fit decision and output register; depends on gtaap_pkg

module gtaap_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gtaap_pkg::cmd_t                     cmd,
  input  logic                                in_restart,
  input  logic [gtaap_pkg::CELL_W-1:0]        in_cells_x,
  input  logic [gtaap_pkg::CELL_W-1:0]        in_cells_y,
  input  logic [gtaap_pkg::CELL_W-1:0]        in_cells_z,
  input  logic [gtaap_pkg::BRICK_W-1:0]       in_brick_count,
  input  logic                                cfg_we,
  input  logic [gtaap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtaap_pkg::CFG_W-1:0]         cfg_wdata,
  output gtaap_pkg::res_t                     out_data
);

  // configuration
  logic [gtaap_pkg::CELL_W-1:0]   axis_limit_r;
  logic [gtaap_pkg::BUDGET_W-1:0] texel_budget_r;
  logic [gtaap_pkg::SLOT_W-1:0]   slot_capacity_r;
  logic [gtaap_pkg::VOL_W-1:0]    volume_limit_r;

  // packing state
  logic [gtaap_pkg::EXT_W-1:0]    ext_r [gtaap_pkg::NPACK][gtaap_pkg::NPACK];
  logic [gtaap_pkg::BUDGET_W-1:0] tex_r [gtaap_pkg::NPACK];
  logic [gtaap_pkg::NPACK-1:0]    usable_r;
  logic [gtaap_pkg::SLOT_W-1:0]   slot_total_r;
  logic [gtaap_pkg::VOL_W-1:0]    packed_total_r;

  // current box and products
  logic [gtaap_pkg::CELL_W-1:0]   cells_r [gtaap_pkg::NPACK];
  logic [gtaap_pkg::BRICK_W-1:0]  bricks_r;
  logic [gtaap_pkg::PROD1_W-1:0]  prod_r;
  logic [gtaap_pkg::TEX_W-1:0]    gtex_r [gtaap_pkg::NPACK];

  // decided result, waiting for the output register
  logic                           acc_r;
  logic [gtaap_pkg::SKIP_W-1:0]   reason_r;
  logic [gtaap_pkg::IDX_W-1:0]    idx_r;
  logic [gtaap_pkg::BASE_W-1:0]   base_r;
  logic [gtaap_pkg::OFF_W-1:0]    offs_r [gtaap_pkg::NPACK];
  gtaap_pkg::res_t                out_r;

  logic [gtaap_pkg::GROW_W-1:0]   grown [gtaap_pkg::NPACK][gtaap_pkg::NPACK];
  logic [gtaap_pkg::GROW_W-1:0]   g_sel [gtaap_pkg::NPACK];
  logic [gtaap_pkg::NPACK-1:0]    ok;
  logic [gtaap_pkg::NPACK-1:0]    fitting;
  logic [gtaap_pkg::PROD1_W-1:0]  mul_a;
  logic [gtaap_pkg::CELL_W-1:0]   mul_b;
  logic [gtaap_pkg::TEX_W-1:0]    mul_res;
  logic [gtaap_pkg::VOL_W-1:0]    limit;
  logic                           full;
  logic [gtaap_pkg::NSLOT_W-1:0]  next_slots;
  logic                           over;
  logic                           accept_w;
  logic                           found;
  logic [gtaap_pkg::AXIS_W-1:0]   best_axis;
  logic [gtaap_pkg::BUDGET_W-1:0] best_tex;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_limit_r    <= gtaap_pkg::AXIS_LIMIT_RST;
      texel_budget_r  <= gtaap_pkg::TEXEL_BUDGET_RST;
      slot_capacity_r <= gtaap_pkg::SLOT_CAPACITY_RST;
      volume_limit_r  <= gtaap_pkg::VOLUME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtaap_pkg::CFG_AXIS_LIMIT:    axis_limit_r    <= cfg_wdata[gtaap_pkg::CELL_W-1:0];
        gtaap_pkg::CFG_TEXEL_BUDGET:  texel_budget_r  <= cfg_wdata[gtaap_pkg::BUDGET_W-1:0];
        gtaap_pkg::CFG_SLOT_CAPACITY: slot_capacity_r <= cfg_wdata[gtaap_pkg::SLOT_W-1:0];
        gtaap_pkg::CFG_VOLUME_LIMIT:  volume_limit_r  <= cfg_wdata[gtaap_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // grown extents of each packing and their per-axis check
  always_comb begin
    for (int p = 0; p < gtaap_pkg::NPACK; p++) begin
      ok[p] = 1'b1;
      for (int a = 0; a < gtaap_pkg::NPACK; a++) begin
        if (a == p) begin
          grown[p][a] = {1'b0, ext_r[p][a]} + {1'b0, cells_r[a]};
        end else if (ext_r[p][a] > cells_r[a]) begin
          grown[p][a] = {1'b0, ext_r[p][a]};
        end else begin
          grown[p][a] = {1'b0, cells_r[a]};
        end
        if (grown[p][a] > {1'b0, axis_limit_r}) begin
          ok[p] = 1'b0;
        end
      end
    end
  end

  // shared multiplier; a packing that passes the axis check has 15-bit extents
  always_comb begin
    case (cmd.pack)
      2'd1:    g_sel = grown[1];
      2'd2:    g_sel = grown[2];
      default: g_sel = grown[0];
    endcase
    mul_a   = cmd.phase ? prod_r : {{(gtaap_pkg::PROD1_W - gtaap_pkg::CELL_W){1'b0}},
                                    g_sel[0][gtaap_pkg::CELL_W-1:0]};
    mul_b   = cmd.phase ? g_sel[2][gtaap_pkg::CELL_W-1:0] : g_sel[1][gtaap_pkg::CELL_W-1:0];
    mul_res = mul_a * mul_b;
  end

  // fit decision
  always_comb begin
    limit      = (volume_limit_r < gtaap_pkg::MAX_BOXES) ? volume_limit_r
                                                         : gtaap_pkg::MAX_BOXES;
    full       = packed_total_r >= limit;
    next_slots = {1'b0, slot_total_r} +
                 {{(gtaap_pkg::NSLOT_W - gtaap_pkg::BRICK_W){1'b0}}, bricks_r};
    over       = next_slots > {1'b0, slot_capacity_r};
    for (int p = 0; p < gtaap_pkg::NPACK; p++) begin
      fitting[p] = ok[p] && usable_r[p] && (gtex_r[p] <= {2'b00, texel_budget_r});
    end
    accept_w = !full && !over && (fitting != '0);
  end

  // usable packing with fewest texels, lowest axis on a tie
  always_comb begin
    found     = 1'b0;
    best_axis = '0;
    best_tex  = '0;
    for (int p = 0; p < gtaap_pkg::NPACK; p++) begin
      if (usable_r[p] && (!found || tex_r[p] < best_tex)) begin
        found     = 1'b1;
        best_axis = gtaap_pkg::AXIS_W'(p);
        best_tex  = tex_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && in_restart)) begin
      for (int p = 0; p < gtaap_pkg::NPACK; p++) begin
        tex_r[p] <= '0;
        for (int a = 0; a < gtaap_pkg::NPACK; a++) begin
          ext_r[p][a] <= '0;
        end
      end
      usable_r       <= gtaap_pkg::ALL_AXES;
      slot_total_r   <= '0;
      packed_total_r <= '0;
    end else if (cmd.decide && accept_w) begin
      for (int p = 0; p < gtaap_pkg::NPACK; p++) begin
        if (fitting[p]) begin
          tex_r[p] <= gtex_r[p][gtaap_pkg::BUDGET_W-1:0];
          for (int a = 0; a < gtaap_pkg::NPACK; a++) begin
            ext_r[p][a] <= grown[p][a][gtaap_pkg::EXT_W-1:0];
          end
        end
      end
      usable_r       <= fitting;
      slot_total_r   <= next_slots[gtaap_pkg::SLOT_W-1:0];
      packed_total_r <= packed_total_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cells_r[0] <= in_cells_x;
      cells_r[1] <= in_cells_y;
      cells_r[2] <= in_cells_z;
      bricks_r   <= in_brick_count;
    end
    if (cmd.mul_en) begin
      if (!cmd.phase) begin
        prod_r <= mul_res[gtaap_pkg::PROD1_W-1:0];
      end else begin
        gtex_r[cmd.pack] <= mul_res;
      end
    end
    if (cmd.decide) begin
      acc_r    <= accept_w;
      reason_r <= full ? gtaap_pkg::SKIP_FULL
                       : (accept_w ? gtaap_pkg::SKIP_NONE : gtaap_pkg::SKIP_NOFIT);
      idx_r    <= accept_w ? packed_total_r[gtaap_pkg::IDX_W-1:0] : '0;
      base_r   <= accept_w ? slot_total_r[gtaap_pkg::BASE_W-1:0] : '0;
      for (int p = 0; p < gtaap_pkg::NPACK; p++) begin
        offs_r[p] <= (accept_w && fitting[p]) ? ext_r[p][p][gtaap_pkg::OFF_W-1:0] : '0;
      end
    end
    if (cmd.publish) begin
      out_r.accepted          <= acc_r;
      out_r.skip_reason       <= reason_r;
      out_r.packed_index      <= idx_r;
      out_r.slot_base         <= base_r;
      out_r.offset_in_x_stack <= offs_r[0];
      out_r.offset_in_y_stack <= offs_r[1];
      out_r.offset_in_z_stack <= offs_r[2];
      out_r.best_axis         <= best_axis;
      out_r.best_texels       <= best_tex;
      out_r.total_slots       <= slot_total_r;
    end
  end

  assign out_data = out_r;

  a_usable_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    usable_r != 3'b000)
    else $error("no usable packing left");

  a_packed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    packed_total_r <= gtaap_pkg::MAX_BOXES)
    else $error("packed count beyond box maximum");

  a_accept_grows_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && accept_w && !(cmd.load && in_restart)) |=>
      packed_total_r == $past(packed_total_r) + 7'd1)
    else $error("accepted box did not advance packed count");

endmodule

// ===== sv/greedy_three_axis_atlas_packer.sv =====
// greedy_three_axis_atlas_packer: top level of the three-axis atlas packer
// depends on gtaap_pkg, gtaap_in_if, gtaap_out_if, gtaap_ctrl, gtaap_dp
//
//   port       dir   handshake          beat contents
//   in_chan    in    valid/ready        restart, cells_x/y/z, brick_count
//   out_chan   out   valid/ready        accept flag, skip reason, index, slot base,
//                                       three offsets, best axis/texels, slot total
//   cfg_*      in    cfg_we only        register index, write data (43 bits)
//
// a box goes from the accept state through the multiply steps on the one shared
// 30x15 multiplier, then through the decide and publish states
// the next box is accepted right after publish, while the result may still wait
// in the output register; a stalled output holds the publish cycle only
// reset (rst_n low, synchronous) restores register defaults and clears packing state
// restart on a box clears packing state in the accept cycle of that box

module greedy_three_axis_atlas_packer (
  input  logic                                clk,
  input  logic                                rst_n,
  gtaap_in_if.sink                            in_chan,
  gtaap_out_if.source                         out_chan,
  input  logic                                cfg_we,
  input  logic [gtaap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtaap_pkg::CFG_W-1:0]         cfg_wdata
);

  gtaap_pkg::cmd_t  cmd;
  gtaap_pkg::res_t  res;

  // sequencer: owns the handshakes and the output valid flag
  gtaap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  // datapath: config, packing state, multiplier, decision and result register
  gtaap_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_restart     (in_chan.restart),
    .in_cells_x     (in_chan.cells_x),
    .in_cells_y     (in_chan.cells_y),
    .in_cells_z     (in_chan.cells_z),
    .in_brick_count (in_chan.brick_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_data       (res)
  );

  // result beat fields
  assign out_chan.accepted          = res.accepted;
  assign out_chan.skip_reason       = res.skip_reason;
  assign out_chan.packed_index      = res.packed_index;
  assign out_chan.slot_base         = res.slot_base;
  assign out_chan.offset_in_x_stack = res.offset_in_x_stack;
  assign out_chan.offset_in_y_stack = res.offset_in_y_stack;
  assign out_chan.offset_in_z_stack = res.offset_in_z_stack;
  assign out_chan.best_axis         = res.best_axis;
  assign out_chan.best_texels       = res.best_texels;
  assign out_chan.total_slots       = res.total_slots;

endmodule

// ===== sim/tb_greedy_three_axis_atlas_packer.sv =====
`timescale 1ns / 1ps
// tb_greedy_three_axis_atlas_packer: self-checking bench for the three-axis atlas packer
// depends on gtaap_pkg, gtaap_in_if, gtaap_out_if and greedy_three_axis_atlas_packer

module tb_greedy_three_axis_atlas_packer;

  localparam int HOLD_OFF_CYCLES = 400;
  // time for one box through the block plus the output register, with margin
  localparam int DRAIN_CYCLES    = 16;
  localparam int RAND_PHASES     = 7;
  localparam int BOXES_PER_PHASE = 162;

  // one row of the directed plan: optional register write, then one box
  typedef struct {
    logic                            wr_en;
    logic [gtaap_pkg::CFG_IDX_W-1:0] wr_idx;
    logic [gtaap_pkg::CFG_W-1:0]     wr_val;
    logic                            restart;
    logic [gtaap_pkg::CELL_W-1:0]    cx;
    logic [gtaap_pkg::CELL_W-1:0]    cy;
    logic [gtaap_pkg::CELL_W-1:0]    cz;
    logic [gtaap_pkg::BRICK_W-1:0]   bricks;
    logic                            fixed;
    gtaap_pkg::res_t                 fixed_res;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [gtaap_pkg::CFG_IDX_W-1:0] cfg_index = gtaap_pkg::CFG_AXIS_LIMIT;
  logic [gtaap_pkg::CFG_W-1:0]     cfg_wdata = '0;

  gtaap_in_if  in_chan();
  gtaap_out_if out_chan();

  greedy_three_axis_atlas_packer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the configuration registers
  logic [gtaap_pkg::CELL_W-1:0]   lim_axis;
  logic [gtaap_pkg::BUDGET_W-1:0] lim_texels;
  logic [gtaap_pkg::SLOT_W-1:0]   cap_slots;
  logic [gtaap_pkg::VOL_W-1:0]    lim_boxes;

  // shadow packing state: pk_ext[packing*3 + axis]
  logic [63:0]                 pk_ext [9];
  logic [gtaap_pkg::NPACK-1:0] live_axes;
  logic [63:0]                 slots_used;
  logic [gtaap_pkg::VOL_W-1:0] boxes_packed;

  gtaap_pkg::res_t pending_results [$];
  plan_row_t       plan [$];
  int              mismatches = 0;

  // traffic shaping knobs: tx_calm for the sender, rx_calm and hold_off for the receiver
  logic tx_calm  = 1'b0;
  logic rx_calm  = 1'b0;
  logic hold_off = 1'b0;

  const logic [gtaap_pkg::CFG_IDX_W-1:0] reg_order [4] =
    '{gtaap_pkg::CFG_AXIS_LIMIT, gtaap_pkg::CFG_TEXEL_BUDGET,
      gtaap_pkg::CFG_SLOT_CAPACITY, gtaap_pkg::CFG_VOLUME_LIMIT};

  function automatic void clear_packing();
    for (int i = 0; i < 9; i++) pk_ext[i] = '0;
    live_axes    = gtaap_pkg::ALL_AXES;
    slots_used   = '0;
    boxes_packed = '0;
  endfunction

  // predicts the result of one box and advances the shadow packing state
  function automatic gtaap_pkg::res_t pack_box(input logic restart,
                                               input logic [gtaap_pkg::CELL_W-1:0] cx,
                                               input logic [gtaap_pkg::CELL_W-1:0] cy,
                                               input logic [gtaap_pkg::CELL_W-1:0] cz,
                                               input logic [gtaap_pkg::BRICK_W-1:0] bricks);
    logic [63:0]                 cells [3];
    logic [63:0]                 grown [9];
    logic [63:0]                 offs [3];
    logic [63:0]                 next_slots;
    logic [63:0]                 box_cap;
    logic [63:0]                 tex;
    logic [63:0]                 best_tex;
    logic [gtaap_pkg::NPACK-1:0] fits;
    logic                        ok;
    logic                        found;
    logic [1:0]                  best_ax;
    gtaap_pkg::res_t             r;
    if (restart) clear_packing();
    cells[0] = 64'(cx);
    cells[1] = 64'(cy);
    cells[2] = 64'(cz);
    for (int p = 0; p < 3; p++) offs[p] = '0;
    r    = '0;
    fits = '0;
    box_cap = (lim_boxes < gtaap_pkg::MAX_BOXES) ? 64'(lim_boxes) : 64'(gtaap_pkg::MAX_BOXES);
    if (64'(boxes_packed) >= box_cap) begin
      r.skip_reason = gtaap_pkg::SKIP_FULL;
    end else begin
      next_slots = slots_used + 64'(bricks);
      // grow each packing: sum on its own axis, max on the other two
      for (int p = 0; p < 3; p++) begin
        ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
          if (a == p) begin
            grown[p*3+a] = pk_ext[p*3+a] + cells[a];
          end else begin
            grown[p*3+a] = (pk_ext[p*3+a] > cells[a]) ? pk_ext[p*3+a] : cells[a];
          end
          if (grown[p*3+a] > 64'(lim_axis)) ok = 1'b0;
        end
        if (ok && grown[p*3] * grown[p*3+1] * grown[p*3+2] <= 64'(lim_texels)) fits[p] = 1'b1;
      end
      fits &= live_axes;
      if (next_slots > 64'(cap_slots) || fits == '0) begin
        r.skip_reason = gtaap_pkg::SKIP_NOFIT;
      end else begin
        r.accepted     = 1'b1;
        r.skip_reason  = gtaap_pkg::SKIP_NONE;
        r.packed_index = boxes_packed[gtaap_pkg::IDX_W-1:0];
        r.slot_base    = slots_used[gtaap_pkg::BASE_W-1:0];
        for (int p = 0; p < 3; p++) begin
          if (fits[p]) begin
            offs[p] = pk_ext[p*3+p];
            for (int a = 0; a < 3; a++) pk_ext[p*3+a] = grown[p*3+a];
          end
        end
        live_axes    = fits;
        slots_used   = next_slots;
        boxes_packed = boxes_packed + 7'd1;
      end
    end
    // cheapest usable packing, lowest axis on a tie
    found    = 1'b0;
    best_ax  = '0;
    best_tex = '0;
    for (int p = 0; p < 3; p++) begin
      if (live_axes[p]) begin
        tex = pk_ext[p*3] * pk_ext[p*3+1] * pk_ext[p*3+2];
        if (!found || tex < best_tex) begin
          found    = 1'b1;
          best_ax  = 2'(p);
          best_tex = tex;
        end
      end
    end
    r.offset_in_x_stack = offs[0][gtaap_pkg::OFF_W-1:0];
    r.offset_in_y_stack = offs[1][gtaap_pkg::OFF_W-1:0];
    r.offset_in_z_stack = offs[2][gtaap_pkg::OFF_W-1:0];
    r.best_axis         = best_ax;
    r.best_texels       = best_tex[gtaap_pkg::BUDGET_W-1:0];
    r.total_slots       = slots_used[gtaap_pkg::SLOT_W-1:0];
    return r;
  endfunction

  function automatic gtaap_pkg::res_t want(input logic acc,
                                           input logic [gtaap_pkg::SKIP_W-1:0] why,
                                           input logic [gtaap_pkg::IDX_W-1:0] idx,
                                           input logic [gtaap_pkg::BASE_W-1:0] base,
                                           input logic [gtaap_pkg::OFF_W-1:0] ox,
                                           input logic [gtaap_pkg::OFF_W-1:0] oy,
                                           input logic [gtaap_pkg::OFF_W-1:0] oz,
                                           input logic [gtaap_pkg::AXIS_W-1:0] ax,
                                           input logic [gtaap_pkg::BUDGET_W-1:0] tex,
                                           input logic [gtaap_pkg::SLOT_W-1:0] slots);
    gtaap_pkg::res_t r;
    r.accepted          = acc;
    r.skip_reason       = why;
    r.packed_index      = idx;
    r.slot_base         = base;
    r.offset_in_x_stack = ox;
    r.offset_in_y_stack = oy;
    r.offset_in_z_stack = oz;
    r.best_axis         = ax;
    r.best_texels       = tex;
    r.total_slots       = slots;
    return r;
  endfunction

  function automatic void add_row(input logic wr_en,
                                  input logic [gtaap_pkg::CFG_IDX_W-1:0] wr_idx,
                                  input logic [gtaap_pkg::CFG_W-1:0] wr_val,
                                  input logic restart,
                                  input logic [gtaap_pkg::CELL_W-1:0] cx,
                                  input logic [gtaap_pkg::CELL_W-1:0] cy,
                                  input logic [gtaap_pkg::CELL_W-1:0] cz,
                                  input logic [gtaap_pkg::BRICK_W-1:0] bricks,
                                  input logic fixed, input gtaap_pkg::res_t fixed_res);
    plan_row_t row;
    row.wr_en     = wr_en;
    row.wr_idx    = wr_idx;
    row.wr_val    = wr_val;
    row.restart   = restart;
    row.cx        = cx;
    row.cy        = cy;
    row.cz        = cz;
    row.bricks    = bricks;
    row.fixed     = fixed;
    row.fixed_res = fixed_res;
    plan.insert(plan.size(), row);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [gtaap_pkg::CELL_W-1:0] pick_cell(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return gtaap_pkg::CELL_W'(1);
    if (roll < 6) return '1;
    if (roll < 12) return gtaap_pkg::CELL_W'($urandom);
    return gtaap_pkg::CELL_W'($urandom_range(1, span));
  endfunction

  function automatic logic [gtaap_pkg::BRICK_W-1:0] pick_bricks(input int unsigned share);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 15) return '1;
    if (roll < 20) return gtaap_pkg::BRICK_W'($urandom);
    return gtaap_pkg::BRICK_W'($urandom_range(0, share));
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // registers selected by sel, written one per clock in index order
  task automatic program_regs(input logic [3:0] sel,
                              input logic [gtaap_pkg::CFG_W-1:0] v_axis,
                              input logic [gtaap_pkg::CFG_W-1:0] v_budget,
                              input logic [gtaap_pkg::CFG_W-1:0] v_cap,
                              input logic [gtaap_pkg::CFG_W-1:0] v_vol);
    logic [gtaap_pkg::CFG_W-1:0] vals [4];
    vals[0] = v_axis;
    vals[1] = v_budget;
    vals[2] = v_cap;
    vals[3] = v_vol;
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= reg_order[i];
        cfg_wdata <= vals[i];
        @(posedge clk);
        case (reg_order[i])
          gtaap_pkg::CFG_AXIS_LIMIT:    lim_axis   = vals[i][gtaap_pkg::CELL_W-1:0];
          gtaap_pkg::CFG_TEXEL_BUDGET:  lim_texels = vals[i][gtaap_pkg::BUDGET_W-1:0];
          gtaap_pkg::CFG_SLOT_CAPACITY: cap_slots  = vals[i][gtaap_pkg::SLOT_W-1:0];
          gtaap_pkg::CFG_VOLUME_LIMIT:  lim_boxes  = vals[i][gtaap_pkg::VOL_W-1:0];
          default: ;
        endcase
      end
    end
    cfg_we <= 1'b0;
  endtask

  // offer one box until it is taken, book its expected result, then maybe idle
  task automatic send_box(input logic restart, input logic [gtaap_pkg::CELL_W-1:0] cx,
                          input logic [gtaap_pkg::CELL_W-1:0] cy,
                          input logic [gtaap_pkg::CELL_W-1:0] cz,
                          input logic [gtaap_pkg::BRICK_W-1:0] bricks, input logic fixed,
                          input gtaap_pkg::res_t fixed_res);
    gtaap_pkg::res_t r;
    int unsigned     gap;
    in_chan.valid       <= 1'b1;
    in_chan.restart     <= restart;
    in_chan.cells_x     <= cx;
    in_chan.cells_y     <= cy;
    in_chan.cells_z     <= cz;
    in_chan.brick_count <= bricks;
    do @(posedge clk); while (!in_chan.ready);
    // predictor always steps so its state follows the block, typed rows override
    r = pack_box(restart, cx, cy, cz, bricks);
    pending_results.insert(pending_results.size(), fixed ? fixed_res : r);
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender stops and waits until every booked result is back, then lets the block settle
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker: every result beat against the oldest booked expectation
  always @(posedge clk) begin
    gtaap_pkg::res_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no box waiting for it");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("accepted", 64'(exp_r.accepted), 64'(out_chan.accepted));
        check_field("skip_reason", 64'(exp_r.skip_reason), 64'(out_chan.skip_reason));
        check_field("packed_index", 64'(exp_r.packed_index), 64'(out_chan.packed_index));
        check_field("slot_base", 64'(exp_r.slot_base), 64'(out_chan.slot_base));
        check_field("offset_in_x_stack", 64'(exp_r.offset_in_x_stack),
                    64'(out_chan.offset_in_x_stack));
        check_field("offset_in_y_stack", 64'(exp_r.offset_in_y_stack),
                    64'(out_chan.offset_in_y_stack));
        check_field("offset_in_z_stack", 64'(exp_r.offset_in_z_stack),
                    64'(out_chan.offset_in_z_stack));
        check_field("best_axis", 64'(exp_r.best_axis), 64'(out_chan.best_axis));
        check_field("best_texels", 64'(exp_r.best_texels), 64'(out_chan.best_texels));
        check_field("total_slots", 64'(exp_r.total_slots), 64'(out_chan.total_slots));
      end
    end
  end

  // result receiver: ready windows with random stalls, plus the long hold-off on request
  initial begin
    int unsigned stall;
    out_chan.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        // block fills up behind this and has to stall its input
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap(rx_calm);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #8_000_000;
    $display("greedy_three_axis_atlas_packer regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    plan_row_t                   row;
    gtaap_pkg::res_t             none_r;
    gtaap_pkg::res_t             nofit_r;
    logic [gtaap_pkg::CFG_W-1:0] p_axis;
    logic [gtaap_pkg::CFG_W-1:0] p_budget;
    logic [gtaap_pkg::CFG_W-1:0] p_cap;
    logic [gtaap_pkg::CFG_W-1:0] p_vol;
    longint unsigned             root;
    longint unsigned             span;
    longint unsigned             share;
    int unsigned                 seq_span;
    int unsigned                 run_len;
    int                          sent;

    in_chan.valid       = 1'b0;
    in_chan.restart     = 1'b0;
    in_chan.cells_x     = '0;
    in_chan.cells_y     = '0;
    in_chan.cells_z     = '0;
    in_chan.brick_count = '0;

    lim_axis   = gtaap_pkg::AXIS_LIMIT_RST;
    lim_texels = gtaap_pkg::TEXEL_BUDGET_RST;
    cap_slots  = gtaap_pkg::SLOT_CAPACITY_RST;
    lim_boxes  = gtaap_pkg::VOLUME_LIMIT_RST;
    clear_packing();

    none_r  = '0;
    nofit_r = want(1'b0, gtaap_pkg::SKIP_NOFIT, '0, '0, '0, '0, '0, '0, '0, '0);

    // directed plan, starting from reset values
    // first box after reset: every packing becomes one cell
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b1, 1, 1, 1, 0, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 0, 0, 0, 0, 0, 0, 1, 0));
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 2, 1, 1, 10, 1'b0, none_r);
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 3, 1, 5, 1'b0, none_r);
    // largest brick count overflows the slot pool
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 1, 4, '1, 1'b0, none_r);
    // all fields at their top on cleared state
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b1, '1, '1, '1, '1, 1'b1, nofit_r);
    // one slot over capacity, then exactly at capacity
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b1, 1, 1, 1, 32769, 1'b1, nofit_r);
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b1, 1, 1, 1, 32768, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 0, 0, 0, 0, 0, 0, 1, 32768));
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 1, 1, 0, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 1, 32768, 1, 1, 1, 0, 2, 32768));
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 1, 1, 1, 1'b1,
            want(1'b0, gtaap_pkg::SKIP_NOFIT, 0, 0, 0, 0, 0, 0, 2, 32768));
    // box right at the axis limit, next one drops the x packing, y and z tie
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b1, 2048, 1, 1, 0, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 0, 0, 0, 0, 0, 0, 2048, 0));
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 1, 1, 0, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 1, 0, 0, 1, 1, 1, 4096, 0));
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 2048, 1, 0, 1'b0, none_r);
    // zero volume limit skips everything
    add_row(1'b1, gtaap_pkg::CFG_VOLUME_LIMIT, 0, 1'b1, 1, 1, 1, 0, 1'b1,
            want(1'b0, gtaap_pkg::SKIP_FULL, 0, 0, 0, 0, 0, 0, 0, 0));
    // volume limit of one: first box in, second refused
    add_row(1'b1, gtaap_pkg::CFG_VOLUME_LIMIT, 1, 1'b1, 1, 1, 1, 7, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 0, 0, 0, 0, 0, 0, 1, 7));
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 1, 1, 0, 1'b1,
            want(1'b0, gtaap_pkg::SKIP_FULL, 0, 0, 0, 0, 0, 0, 1, 7));
    // volume limit above the box cap
    add_row(1'b1, gtaap_pkg::CFG_VOLUME_LIMIT, '1, 1'b0, 3, 3, 3, 0, 1'b0, none_r);
    // widest axis limit, texel budget still at reset
    add_row(1'b1, gtaap_pkg::CFG_AXIS_LIMIT, '1, 1'b1, 16384, 16384, 1, 0, 1'b1, nofit_r);
    // widest texel budget, still short of a full-size cube
    add_row(1'b1, gtaap_pkg::CFG_TEXEL_BUDGET, '1, 1'b1, '1, '1, '1, 0, 1'b1, nofit_r);
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b1, 16384, 16384, 1, 0, 1'b1,
            want(1'b1, gtaap_pkg::SKIP_NONE, 0, 0, 0, 0, 0, 0, 268435456, 0));
    // offsets past 14 bits wrap, x packing drops
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 16384, 1, 1, 0, 1'b0, none_r);
    add_row(1'b0, gtaap_pkg::CFG_AXIS_LIMIT, '0, 1'b0, 1, 1, 1, 0, 1'b0, none_r);
    add_row(1'b1, gtaap_pkg::CFG_SLOT_CAPACITY, '1, 1'b0, 1, 1, 1, '1, 1'b0, none_r);
    // zero axis limit fits nothing
    add_row(1'b1, gtaap_pkg::CFG_AXIS_LIMIT, 0, 1'b1, 1, 1, 1, 0, 1'b1, nofit_r);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.wr_en) begin
        wait_drained();
        program_regs(4'b0001 << row.wr_idx, row.wr_val, row.wr_val, row.wr_val, row.wr_val);
      end
      send_box(row.restart, row.cx, row.cy, row.cz, row.bricks, row.fixed, row.fixed_res);
    end
    wait_drained();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          p_axis   = gtaap_pkg::CFG_W'(gtaap_pkg::AXIS_LIMIT_RST);
          p_budget = gtaap_pkg::CFG_W'(gtaap_pkg::TEXEL_BUDGET_RST);
          p_cap    = gtaap_pkg::CFG_W'(gtaap_pkg::SLOT_CAPACITY_RST);
          p_vol    = gtaap_pkg::CFG_W'(gtaap_pkg::VOLUME_LIMIT_RST);
        end
        1: begin
          // top of the documented ranges
          p_axis   = gtaap_pkg::CFG_W'(16384);
          p_budget = gtaap_pkg::CFG_W'(1) << 42;
          p_cap    = gtaap_pkg::CFG_W'(1) << 32;
          p_vol    = gtaap_pkg::CFG_W'(64);
        end
        2: begin
          // every register bit set
          p_axis   = gtaap_pkg::CFG_W'(15'h7FFF);
          p_budget = '1;
          p_cap    = gtaap_pkg::CFG_W'(33'h1_FFFF_FFFF);
          p_vol    = gtaap_pkg::CFG_W'(7'h7F);
        end
        3: begin
          // tightest setting, nothing but unit boxes with no bricks can pass
          p_axis   = gtaap_pkg::CFG_W'(1);
          p_budget = gtaap_pkg::CFG_W'(1);
          p_cap    = '0;
          p_vol    = gtaap_pkg::CFG_W'(1);
        end
        5: begin
          p_axis   = gtaap_pkg::CFG_W'(512);
          p_budget = gtaap_pkg::CFG_W'(30000000);
          p_cap    = gtaap_pkg::CFG_W'(200000);
          p_vol    = gtaap_pkg::CFG_W'(12);
        end
        default: begin
          p_axis   = gtaap_pkg::CFG_W'($urandom_range(1, 4096));
          p_budget = gtaap_pkg::CFG_W'({$urandom, $urandom} >> $urandom_range(21, 63));
          p_cap    = gtaap_pkg::CFG_W'({$urandom, $urandom} >> $urandom_range(31, 63));
          p_vol    = gtaap_pkg::CFG_W'($urandom_range(0, 20));
        end
      endcase
      program_regs(4'hF, p_axis, p_budget, p_cap, p_vol);

      tx_calm = (ph == 2);
      rx_calm = (ph == 5);
      if (ph == 1 || ph == 4) hold_off = 1'b1;

      // box sizes scaled so a run of boxes fills the atlas rather than failing at once
      root = 1;
      while (root < 16384 && (2 * root) * (2 * root) * (2 * root) <= 64'(lim_texels))
        root = root * 2;
      span = (64'(lim_axis) / 4 < root / 2) ? 64'(lim_axis) / 4 : root / 2;
      if (span == 0) span = 1;
      share = 64'(cap_slots) / 10 + 1;
      if (share > 64'h1F_FFFF) share = 64'h1F_FFFF;

      sent = 0;
      while (sent < BOXES_PER_PHASE) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise: anything the fields allow, restart at random
          send_box(1'($urandom), gtaap_pkg::CELL_W'($urandom), gtaap_pkg::CELL_W'($urandom),
                   gtaap_pkg::CELL_W'($urandom), gtaap_pkg::BRICK_W'($urandom), 1'b0, none_r);
          sent++;
        end else begin
          // one scene load: restart, then a run of boxes of similar scale
          run_len  = $urandom_range(1, 24);
          seq_span = $urandom_range(1, int'(span));
          for (int k = 0; k < run_len && sent < BOXES_PER_PHASE; k++) begin
            send_box(k == 0, pick_cell(seq_span), pick_cell(seq_span), pick_cell(seq_span),
                     pick_bricks(int'(share)), 1'b0, none_r);
            sent++;
          end
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("greedy_three_axis_atlas_packer regression: pass");
    end else begin
      $display("greedy_three_axis_atlas_packer regression: fail");
    end
    $finish;
  end

endmodule
